### src/cpcf_pkg.sv
// Shared types for the circle pair collision finder.
// Holds the stored circle record, controller states and the
// command/status bundles between controller and datapath. No dependencies.
package cpcf_pkg;

    // Field widths of one circle request
    localparam int ID_W    = 16;
    localparam int POS_W   = 16;
    localparam int RAD_W   = 12;
    localparam int MASK_W  = 16;

    // Derived arithmetic widths
    localparam int DIFF_W  = POS_W + 1;          // coordinate difference
    localparam int SQ_W    = 2 * POS_W;          // |diff|^2 fits in 2*POS_W bits
    localparam int RSUM_W  = RAD_W + 1;          // sum of two radii
    localparam int RSQ_W   = 2 * RSUM_W;         // squared radius sum

    // One stored circle
    typedef struct packed {
        logic [ID_W-1:0]          id;
        logic signed [POS_W-1:0]  x;
        logic signed [POS_W-1:0]  y;
        logic [RAD_W-1:0]         r;
        logic [MASK_W-1:0]        layer;
        logic [MASK_W-1:0]        hits;
    } entry_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_LOAD,
        ST_TEST,
        ST_DRAIN,
        ST_CLOSE
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic wr_en;     // store the incoming circle
        logic issue;     // start a pair test this cycle
        logic close;     // emit the batch-closing report
        logic ovf;       // batch overflow flag for reports
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic stall;     // pair pipeline frozen by a full report slot
        logic busy;      // pair tests still in flight
        logic close_ok;  // report slot can take the closing report
    } sts_t;

endpackage

### src/cpcf_if.sv
// Valid/ready channel interfaces for circle requests and pair reports.
// Depends on cpcf_pkg for field widths.
interface cpcf_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [cpcf_pkg::ID_W-1:0]            object_id;
    logic signed [cpcf_pkg::POS_W-1:0]    pos_x;
    logic signed [cpcf_pkg::POS_W-1:0]    pos_y;
    logic [cpcf_pkg::RAD_W-1:0]           radius;
    logic [cpcf_pkg::MASK_W-1:0]          layer_mask;
    logic [cpcf_pkg::MASK_W-1:0]          hit_mask;
    logic                                 last_object;

    modport source (
        output valid, object_id, pos_x, pos_y, radius, layer_mask, hit_mask, last_object,
        input  ready
    );
    modport sink (
        input  valid, object_id, pos_x, pos_y, radius, layer_mask, hit_mask, last_object,
        output ready
    );
endinterface

interface cpcf_out_if;
    logic                            valid;
    logic                            ready;
    logic [cpcf_pkg::ID_W-1:0]       first_id;
    logic [cpcf_pkg::ID_W-1:0]       second_id;
    logic                            pair_valid;
    logic                            overflowed;
    logic                            last_pair;

    modport source (
        output valid, first_id, second_id, pair_valid, overflowed, last_pair,
        input  ready
    );
    modport sink (
        input  valid, first_id, second_id, pair_valid, overflowed, last_pair,
        output ready
    );
endinterface

### src/cpcf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cpcf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### src/cpcf_dp.sv
// Datapath: circle store (two RAM copies), pair test pipeline,
// pending-hit register and report output register.
// Depends on cpcf_pkg, cpcf_if (cpcf_out_if) and cpcf_ram.
module cpcf_dp #(
    parameter int MAX_OBJECTS = 8,
    localparam int AW = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cpcf_pkg::cmd_t       cmd,
    input  logic [AW-1:0]        wr_addr,
    input  logic [AW-1:0]        rd_addr_a,
    input  logic [AW-1:0]        rd_addr_b,
    input  cpcf_pkg::entry_t     wr_data,
    output cpcf_pkg::sts_t       sts,
    cpcf_out_if.source           report
);

    localparam int EW = $bits(cpcf_pkg::entry_t);
    localparam int ID_W = cpcf_pkg::ID_W;

    cpcf_pkg::entry_t ent_a;
    cpcf_pkg::entry_t ent_b;
    logic             stall;
    logic             adv;
    logic             hit;

    // Stage valids
    logic s1_vld_reg, s2_vld_reg, s3_vld_reg;

    // Stage 2: differences, radius sum, layer test
    logic signed [cpcf_pkg::DIFF_W-1:0] dx_reg, dy_reg;
    logic [cpcf_pkg::RSUM_W-1:0]        rs_reg;
    logic                               cand2_reg;
    logic [ID_W-1:0]                    ida2_reg, idb2_reg;

    // Stage 3: squares
    logic signed [2*cpcf_pkg::DIFF_W-1:0] dx_sq, dy_sq;
    logic [cpcf_pkg::RSQ_W-1:0]           rs_sq;
    logic [cpcf_pkg::SQ_W-1:0]            dx2_reg, dy2_reg;
    logic [cpcf_pkg::RSQ_W-1:0]           rs2_reg;
    logic                                 cand3_reg;
    logic [ID_W-1:0]                      ida3_reg, idb3_reg;
    logic [cpcf_pkg::SQ_W:0]              d2;

    // Pending hit and output register
    logic            pend_vld_reg, pend_vld_next;
    logic [ID_W-1:0] pend_a_reg, pend_b_reg;
    logic            out_vld_reg, out_vld_next;
    logic [ID_W-1:0] out_first_reg, out_second_reg;
    logic            out_pair_reg, out_ovf_reg, out_last_reg;
    logic            push_hit, push_close, slot_free;

    // Two copies of the store so both circles of a pair are read in the same cycle
    cpcf_ram #(.WIDTH(EW), .DEPTH(MAX_OBJECTS)) u_ram_a (
        .clk     (clk),
        .wr_en   (cmd.wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.issue && adv),
        .rd_addr (rd_addr_a),
        .rd_data (ent_a)
    );

    cpcf_ram #(.WIDTH(EW), .DEPTH(MAX_OBJECTS)) u_ram_b (
        .clk     (clk),
        .wr_en   (cmd.wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.issue && adv),
        .rd_addr (rd_addr_b),
        .rd_data (ent_b)
    );

    // Hit decision at the end of the pipeline
    assign d2  = {1'b0, dx2_reg} + {1'b0, dy2_reg};
    assign hit = s3_vld_reg && cand3_reg &&
                 (d2 < {{(cpcf_pkg::SQ_W + 1 - cpcf_pkg::RSQ_W){1'b0}}, rs2_reg});

    // Freeze when a second hit needs the occupied report slot
    assign slot_free  = !out_vld_reg || report.ready;
    assign stall      = hit && pend_vld_reg && !slot_free;
    assign adv        = !stall;
    assign push_hit   = hit && pend_vld_reg && adv;
    assign push_close = cmd.close && slot_free;

    assign sts.stall    = stall;
    assign sts.busy     = s1_vld_reg || s2_vld_reg || s3_vld_reg;
    assign sts.close_ok = slot_free;

    // Squares
    assign dx_sq = dx_reg * dx_reg;
    assign dy_sq = dy_reg * dy_reg;
    assign rs_sq = rs_reg * rs_reg;

    // Pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg <= cmd.issue;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
        end
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx_reg    <= {ent_a.x[cpcf_pkg::POS_W-1], ent_a.x}
                       - {ent_b.x[cpcf_pkg::POS_W-1], ent_b.x};
            dy_reg    <= {ent_a.y[cpcf_pkg::POS_W-1], ent_a.y}
                       - {ent_b.y[cpcf_pkg::POS_W-1], ent_b.y};
            rs_reg    <= {1'b0, ent_a.r} + {1'b0, ent_b.r};
            cand2_reg <= |((ent_a.layer & ent_b.hits) | (ent_b.layer & ent_a.hits));
            ida2_reg  <= ent_a.id;
            idb2_reg  <= ent_b.id;

            dx2_reg   <= dx_sq[cpcf_pkg::SQ_W-1:0];
            dy2_reg   <= dy_sq[cpcf_pkg::SQ_W-1:0];
            rs2_reg   <= rs_sq;
            cand3_reg <= cand2_reg;
            ida3_reg  <= ida2_reg;
            idb3_reg  <= idb2_reg;
        end
    end

    // Pending hit and report slot control
    always_comb
    begin
        pend_vld_next = pend_vld_reg;
        if (push_close)
        begin
            pend_vld_next = 1'b0;
        end
        else if (hit && adv)
        begin
            pend_vld_next = 1'b1;
        end

        out_vld_next = out_vld_reg && !report.ready;
        if (push_hit || push_close)
        begin
            out_vld_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    // Pending and report payload
    always_ff @(posedge clk)
    begin
        if (hit && adv)
        begin
            pend_a_reg <= ida3_reg;
            pend_b_reg <= idb3_reg;
        end
        if (push_hit)
        begin
            out_first_reg  <= pend_a_reg;
            out_second_reg <= pend_b_reg;
            out_pair_reg   <= 1'b1;
            out_ovf_reg    <= cmd.ovf;
            out_last_reg   <= 1'b0;
        end
        else if (push_close)
        begin
            out_first_reg  <= pend_vld_reg ? pend_a_reg : '0;
            out_second_reg <= pend_vld_reg ? pend_b_reg : '0;
            out_pair_reg   <= pend_vld_reg;
            out_ovf_reg    <= cmd.ovf;
            out_last_reg   <= 1'b1;
        end
    end

    assign report.valid      = out_vld_reg;
    assign report.first_id   = out_first_reg;
    assign report.second_id  = out_second_reg;
    assign report.pair_valid = out_pair_reg;
    assign report.overflowed = out_ovf_reg;
    assign report.last_pair  = out_last_reg;

    // Closing report only once all pair tests have left the pipeline
    a_close_drained: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.close |-> !sts.busy)
        else $error("closing report requested with pair tests in flight");

    a_close_reports_last: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.close && slot_free) |=> (report.valid && report.last_pair))
        else $error("closing report not presented as last of batch");

endmodule

### src/cpcf_ctrl.sv
// Controller: load counter, pair index sequencer and batch state machine.
// Depends on cpcf_pkg.
module cpcf_ctrl #(
    parameter int MAX_OBJECTS = 8,
    localparam int AW = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1,
    localparam int CW = $clog2(MAX_OBJECTS + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_last,
    output logic              req_ready,
    input  cpcf_pkg::sts_t    sts,
    output cpcf_pkg::cmd_t    cmd,
    output logic [AW-1:0]     wr_addr,
    output logic [AW-1:0]     rd_addr_a,
    output logic [AW-1:0]     rd_addr_b
);

    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_OBJECTS);
    localparam logic [CW-1:0] ONE     = CW'(1);
    localparam logic [CW-1:0] TWO     = CW'(2);

    cpcf_pkg::state_t state_reg, state_next;
    logic [CW-1:0]    cnt_reg, cnt_next, cnt_load;
    logic             ovf_reg, ovf_next;
    logic [AW-1:0]    i_reg, i_next, j_reg, j_next;
    logic             accept, has_room, row_end, last_pair_idx;

    assign accept        = req_valid && req_ready;
    assign has_room      = cnt_reg < CNT_MAX;
    assign cnt_load      = has_room ? cnt_reg + ONE : cnt_reg;
    assign row_end       = (CW'(j_reg) + ONE) == cnt_reg;
    assign last_pair_idx = row_end && ((CW'(i_reg) + TWO) == cnt_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cpcf_pkg::ST_LOAD:
            begin
                if (accept && req_last)
                begin
                    state_next = (cnt_load >= TWO) ? cpcf_pkg::ST_TEST : cpcf_pkg::ST_DRAIN;
                end
            end
            cpcf_pkg::ST_TEST:
            begin
                if (!sts.stall && last_pair_idx)
                begin
                    state_next = cpcf_pkg::ST_DRAIN;
                end
            end
            cpcf_pkg::ST_DRAIN:
            begin
                if (!sts.busy)
                begin
                    state_next = cpcf_pkg::ST_CLOSE;
                end
            end
            cpcf_pkg::ST_CLOSE:
            begin
                if (sts.close_ok)
                begin
                    state_next = cpcf_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = cpcf_pkg::ST_LOAD;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        req_ready = (state_reg == cpcf_pkg::ST_LOAD);
        cmd.wr_en = (state_reg == cpcf_pkg::ST_LOAD) && req_valid && has_room;
        cmd.issue = (state_reg == cpcf_pkg::ST_TEST);
        cmd.close = (state_reg == cpcf_pkg::ST_CLOSE);
        cmd.ovf   = ovf_reg;
        wr_addr   = cnt_reg[AW-1:0];
        rd_addr_a = i_reg;
        rd_addr_b = j_reg;
    end

    // Counters and pair indexes
    always_comb
    begin
        cnt_next = cnt_reg;
        ovf_next = ovf_reg;
        i_next   = i_reg;
        j_next   = j_reg;
        if (accept)
        begin
            cnt_next = cnt_load;
            if (!has_room)
            begin
                ovf_next = 1'b1;
            end
            if (req_last)
            begin
                i_next = '0;
                j_next = AW'(ONE);
            end
        end
        else if (state_reg == cpcf_pkg::ST_TEST && !sts.stall)
        begin
            if (row_end)
            begin
                i_next = AW'(CW'(i_reg) + ONE);
                j_next = AW'(CW'(i_reg) + TWO);
            end
            else
            begin
                j_next = AW'(CW'(j_reg) + ONE);
            end
        end
        else if (state_reg == cpcf_pkg::ST_CLOSE && sts.close_ok)
        begin
            cnt_next = '0;
            ovf_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cpcf_pkg::ST_LOAD;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
            i_reg     <= '0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
        end
    end

    // Pair indexes stay ordered and inside the loaded range
    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cpcf_pkg::ST_TEST) |-> (i_reg < j_reg))
        else $error("pair index order broken");

    a_pair_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cpcf_pkg::ST_TEST) |-> (CW'(j_reg) < cnt_reg))
        else $error("pair index beyond loaded circles");

    a_batch_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cpcf_pkg::ST_CLOSE && sts.close_ok) |=> (cnt_reg == '0 && !ovf_reg))
        else $error("batch state not cleared after closing report");

endmodule

### src/circle_pair_collision_finder_unit.sv
// Circle pair collision finder, top level.
// Loads a batch of circles on the circle channel, one request per circle.
// After the request flagged last_object, every stored pair i<j (load order)
// whose layer/hit masks meet is tested: it collides when the squared centre
// distance is below the squared sum of radii. Each colliding pair is sent on
// the report channel; the final report of a batch has last_pair set, and a
// batch with no collision sends one empty report (pair_valid = 0).
// Circles beyond MAX_OBJECTS are dropped and flag overflowed on all reports.
// Timing: circles load at one per cycle while loading; the pair pipeline
// starts one pair per cycle unless stalled by the report slot. The
// one-pair-per-cycle RAM read sets the pace. A new batch is taken once the
// closing report is in the output register. If the report receiver stalls
// while a second hit waits, the pair pipeline freezes until the output
// register frees.
// Reset clears the batch count, the overflow flag and all valid state; the
// circle store holds no reset values and needs no clearing pass.
// Depends on cpcf_pkg, cpcf_if, cpcf_ram, cpcf_dp and cpcf_ctrl.
module circle_pair_collision_finder_unit #(
    parameter int MAX_OBJECTS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    cpcf_in_if.sink     circle,
    cpcf_out_if.source  report
);

    localparam int AW = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;

    cpcf_pkg::cmd_t   cmd;
    cpcf_pkg::sts_t   sts;
    cpcf_pkg::entry_t wr_data;
    logic [AW-1:0]    wr_addr, rd_addr_a, rd_addr_b;
    logic             req_ready;

    // Pack the incoming circle for the store
    assign wr_data.id    = circle.object_id;
    assign wr_data.x     = circle.pos_x;
    assign wr_data.y     = circle.pos_y;
    assign wr_data.r     = circle.radius;
    assign wr_data.layer = circle.layer_mask;
    assign wr_data.hits  = circle.hit_mask;
    assign circle.ready  = req_ready;

    cpcf_ctrl #(.MAX_OBJECTS(MAX_OBJECTS)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (circle.valid),
        .req_last  (circle.last_object),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd),
        .wr_addr   (wr_addr),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b)
    );

    cpcf_dp #(.MAX_OBJECTS(MAX_OBJECTS)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .wr_addr   (wr_addr),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .wr_data   (wr_data),
        .sts       (sts),
        .report    (report)
    );

endmodule

### dv/tb.sv
// Self-checking testbench for circle_pair_collision_finder_unit.
// Streams batches of circle requests and scores every pair report against a shadow predictor.
// Depends on cpcf_pkg, the cpcf_in_if / cpcf_out_if interfaces and the top-level RTL.
module tb;

    localparam int STORE_DEPTH   = 8;
    localparam int SETTLE_CYCLES = 24;
    // Worst case: ~290 requests, each as if it raised 28 reports, each report
    // behind the longest receiver stall plus pipeline latency, then doubled.
    localparam int TIMEOUT       = 4000000;

    typedef struct packed {
        logic [cpcf_pkg::ID_W-1:0] first_id;
        logic [cpcf_pkg::ID_W-1:0] second_id;
        logic                      pair_valid;
        logic                      overflowed;
        logic                      last_pair;
    } pair_report_t;

    logic clk;
    logic rst_n;

    cpcf_in_if  circle ();
    cpcf_out_if report ();

    circle_pair_collision_finder_unit #(
        .MAX_OBJECTS(STORE_DEPTH)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .circle(circle),
        .report(report)
    );

    // Shadow copy of the batch store and the reports it predicts
    cpcf_pkg::entry_t shadow_store [STORE_DEPTH];
    int               shadow_count;
    bit               shadow_ovf;
    pair_report_t     pending_reports [$];

    bit no_idle;
    int errors;
    int circles_sent;
    int batches_sent;
    int ovf_batches;
    int reports_seen;
    int hits_seen;

    // Clock
    initial
    begin : clock_gen
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog
    initial
    begin : watchdog
        #(TIMEOUT);
        $display("TEST FAILED");
        $finish;
    end

    // Candidate filter plus strict overlap test, in exact integer terms
    function automatic bit circles_overlap(cpcf_pkg::entry_t a, cpcf_pkg::entry_t b);
        longint dx;
        longint dy;
        longint rsum;
        if (((a.layer & b.hits) | (b.layer & a.hits)) == '0)
            return 1'b0;
        dx   = longint'($signed(a.x)) - longint'($signed(b.x));
        dy   = longint'($signed(a.y)) - longint'($signed(b.y));
        rsum = longint'(a.r) + longint'(b.r);
        return (dx * dx + dy * dy) < (rsum * rsum);
    endfunction

    function automatic cpcf_pkg::entry_t make_circle(
        logic [cpcf_pkg::ID_W-1:0] id, logic signed [cpcf_pkg::POS_W-1:0] x,
        logic signed [cpcf_pkg::POS_W-1:0] y, logic [cpcf_pkg::RAD_W-1:0] r,
        logic [cpcf_pkg::MASK_W-1:0] layer, logic [cpcf_pkg::MASK_W-1:0] hits);
        cpcf_pkg::entry_t c;
        c.id    = id;
        c.x     = x;
        c.y     = y;
        c.r     = r;
        c.layer = layer;
        c.hits  = hits;
        return c;
    endfunction

    // Store one accepted circle; on the last one, predict the batch's reports
    task automatic track_circle(input cpcf_pkg::entry_t c, input bit last);
        pair_report_t held_rep;
        bit           have_rep;
        have_rep = 1'b0;
        if (shadow_count < STORE_DEPTH)
        begin
            shadow_store[shadow_count] = c;
            shadow_count++;
        end
        else
            shadow_ovf = 1'b1;
        if (last)
        begin
            for (int i = 0; i < shadow_count; i++)
                for (int j = i + 1; j < shadow_count; j++)
                    if (circles_overlap(shadow_store[i], shadow_store[j]))
                    begin
                        if (have_rep)
                            pending_reports.push_back(held_rep);
                        held_rep = '{shadow_store[i].id, shadow_store[j].id,
                                     1'b1, shadow_ovf, 1'b0};
                        have_rep = 1'b1;
                    end
            // no hit: one empty report closes the batch
            if (!have_rep)
                held_rep = '{16'h0000, 16'h0000, 1'b0, shadow_ovf, 1'b0};
            held_rep.last_pair = 1'b1;
            pending_reports.push_back(held_rep);
            if (shadow_ovf)
                ovf_batches++;
            batches_sent++;
            shadow_count = 0;
            shadow_ovf   = 1'b0;
        end
    endtask

    // Send one circle request, with random idle cycles carrying junk payload
    task automatic send_circle(input cpcf_pkg::entry_t c, input bit last);
        while (!no_idle && $urandom_range(99) < 35)
        begin
            circle.valid       <= 1'b0;
            circle.object_id   <= 16'($urandom);
            circle.pos_x       <= 16'($urandom);
            circle.pos_y       <= 16'($urandom);
            circle.radius      <= 12'($urandom);
            circle.layer_mask  <= 16'($urandom);
            circle.hit_mask    <= 16'($urandom);
            circle.last_object <= 1'($urandom_range(1));
            @(posedge clk);
        end
        circle.valid       <= 1'b1;
        circle.object_id   <= c.id;
        circle.pos_x       <= c.x;
        circle.pos_y       <= c.y;
        circle.radius      <= c.r;
        circle.layer_mask  <= c.layer;
        circle.hit_mask    <= c.hits;
        circle.last_object <= last;
        @(posedge clk);
        while (!circle.ready)
            @(posedge clk);
        track_circle(c, last);
        circles_sent++;
    endtask

    // Drop valid so a held request is not taken twice
    task automatic release_circle();
        circle.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_reports_drained();
        release_circle();
        while (pending_reports.size() != 0)
            @(posedge clk);
    endtask

    function automatic void compare_field(string name, logic [15:0] want, logic [15:0] seen);
        if (seen !== want)
        begin
            errors++;
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, seen);
        end
    endfunction

    // Report sink: random ready with occasional long stalls
    initial
    begin : report_sink
        int stall_left;
        stall_left   = 0;
        report.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (no_idle)
                report.ready <= 1'b1;
            else if (stall_left > 0)
            begin
                report.ready <= 1'b0;
                stall_left--;
            end
            else if ($urandom_range(99) < 2)
            begin
                report.ready <= 1'b0;
                stall_left = $urandom_range(5, 16);
            end
            else
                report.ready <= ($urandom_range(99) >= 35);
        end
    end

    // Scoreboard: each accepted report against the oldest prediction
    always @(posedge clk)
    begin
        pair_report_t seen;
        pair_report_t want;
        if (rst_n && report.valid && report.ready)
        begin
            seen = '{report.first_id, report.second_id, report.pair_valid,
                     report.overflowed, report.last_pair};
            reports_seen++;
            if (seen.pair_valid === 1'b1)
                hits_seen++;
            if (pending_reports.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected report: expected none, actual %h", $time, seen);
            end
            else
            begin
                want = pending_reports.pop_front();
                compare_field("first_id",   want.first_id,   seen.first_id);
                compare_field("second_id",  want.second_id,  seen.second_id);
                compare_field("pair_valid", want.pair_valid, seen.pair_valid);
                compare_field("overflowed", want.overflowed, seen.overflowed);
                compare_field("last_pair",  want.last_pair,  seen.last_pair);
            end
        end
    end

    // One circle alone: only the empty closing report, all fields at extremes
    task automatic test_single_circle();
        send_circle(make_circle(16'hFFFF, 16'sh7FFF, 16'sh8000, 12'hFFF, 16'hFFFF, 16'hFFFF),
                    1'b1);
    endtask

    // Distance equal to radius sum does not collide; one more unit does
    task automatic test_touching_boundary();
        send_circle(make_circle(16'h0001, -16'sd12, -16'sd16, 12'd20, 16'hFFFF, 16'hFFFF), 1'b0);
        send_circle(make_circle(16'h0002, 16'sd12, 16'sd16, 12'd20, 16'hFFFF, 16'hFFFF), 1'b1);
        send_circle(make_circle(16'h0003, -16'sd12, -16'sd16, 12'd20, 16'hFFFF, 16'hFFFF), 1'b0);
        send_circle(make_circle(16'h0004, 16'sd12, 16'sd16, 12'd21, 16'hFFFF, 16'hFFFF), 1'b1);
    endtask

    // Coincident circles; only the mask filter decides, in both directions
    task automatic test_mask_filter();
        send_circle(make_circle(16'h0010, 16'sd100, 16'sd100, 12'd8, 16'h0001, 16'h0000), 1'b0);
        send_circle(make_circle(16'h0011, 16'sd100, 16'sd100, 12'd8, 16'h0000, 16'h0001), 1'b0);
        send_circle(make_circle(16'h0012, 16'sd100, 16'sd100, 12'd8, 16'h0000, 16'h8000), 1'b0);
        send_circle(make_circle(16'h0013, 16'sd100, 16'sd100, 12'd8, 16'h8000, 16'h0000), 1'b1);
    endtask

    // Opposite corners with largest radii; zero radii at one point
    task automatic test_extreme_positions();
        send_circle(make_circle(16'h0000, 16'sh8000, 16'sh8000, 12'hFFF, 16'hFFFF, 16'hFFFF),
                    1'b0);
        send_circle(make_circle(16'hFFFF, 16'sh7FFF, 16'sh7FFF, 12'hFFF, 16'hFFFF, 16'hFFFF),
                    1'b1);
        send_circle(make_circle(16'h0000, 16'sd0, 16'sd0, 12'd0, 16'hFFFF, 16'hFFFF), 1'b0);
        send_circle(make_circle(16'h0000, 16'sd0, 16'sd0, 12'd0, 16'hFFFF, 16'hFFFF), 1'b0);
        send_circle(make_circle(16'h0001, 16'sd0, 16'sd0, 12'd1, 16'hFFFF, 16'hFFFF), 1'b1);
    endtask

    // Ten coincident circles: store fills, two dropped, all 28 pairs hit
    task automatic test_store_overflow();
        for (int k = 0; k < 10; k++)
            send_circle(make_circle(16'h0A00 + 16'(k), -16'sd500, 16'sd700, 12'd1,
                                    16'hFFFF, 16'hFFFF), k == 9);
    endtask

    // One random batch: wide scatter, clusters, sparse masks or touching chains
    task automatic send_random_batch();
        int                                size;
        int                                mode;
        int                                spread;
        int                                rmax;
        int                                step;
        int                                pick;
        logic signed [cpcf_pkg::POS_W-1:0] cx;
        logic signed [cpcf_pkg::POS_W-1:0] cy;
        cpcf_pkg::entry_t                  c;
        pick = $urandom_range(99);
        if (pick < 5)
            size = 1;
        else if (pick < 85)
            size = $urandom_range(2, STORE_DEPTH);
        else
            size = $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 4);
        mode   = $urandom_range(3);
        spread = 1 << $urandom_range(2, 12);
        rmax   = (spread > 4095) ? 4095 : spread;
        step   = 2 * $urandom_range(1, 200);
        cx     = 16'($urandom);
        cy     = 16'($urandom);
        for (int k = 0; k < size; k++)
        begin
            c.id = 16'($urandom);
            unique case (mode)
                0:
                begin
                    c.x = 16'($urandom);
                    c.y = 16'($urandom);
                    c.r = 12'($urandom);
                end
                3:
                begin
                    // neighbors touch exactly or overlap by a hair
                    c.x = cx + 16'(k * step);
                    c.y = cy;
                    c.r = 12'(step / 2 + $urandom_range(1));
                end
                default:
                begin
                    c.x = cx + 16'($urandom_range(0, 2 * spread)) - 16'(spread);
                    c.y = cy + 16'($urandom_range(0, 2 * spread)) - 16'(spread);
                    c.r = 12'($urandom_range(0, rmax));
                end
            endcase
            if (mode == 2)
            begin
                c.layer = 16'h0001 << $urandom_range(15);
                c.hits  = 16'h0001 << $urandom_range(15);
            end
            else if (mode == 3 || $urandom_range(2) == 0)
            begin
                c.layer = 16'hFFFF;
                c.hits  = 16'hFFFF;
            end
            else
            begin
                c.layer = 16'($urandom);
                c.hits  = 16'($urandom);
            end
            send_circle(c, k == size - 1);
        end
    endtask

    // Random batches with random idling and the occasional full drain
    task automatic test_random_batches(input int target);
        int start;
        int nbatch;
        start  = circles_sent;
        nbatch = 0;
        while (circles_sent - start < target)
        begin
            send_random_batch();
            nbatch++;
            if (nbatch == 3 || $urandom_range(5) == 0)
                wait_reports_drained();
        end
    endtask

    // Random batches with both sides never idling
    task automatic test_back_to_back(input int target);
        int start;
        start   = circles_sent;
        no_idle = 1'b1;
        while (circles_sent - start < target)
            send_random_batch();
        no_idle = 1'b0;
    endtask

    initial
    begin : main
        rst_n              = 1'b0;
        no_idle            = 1'b0;
        errors             = 0;
        circles_sent       = 0;
        batches_sent       = 0;
        ovf_batches        = 0;
        reports_seen       = 0;
        hits_seen          = 0;
        shadow_count       = 0;
        shadow_ovf         = 1'b0;
        circle.valid       = 1'b0;
        circle.object_id   = '0;
        circle.pos_x       = '0;
        circle.pos_y       = '0;
        circle.radius      = '0;
        circle.layer_mask  = '0;
        circle.hit_mask    = '0;
        circle.last_object = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_circle();
        test_touching_boundary();
        test_mask_filter();
        test_extreme_positions();
        test_store_overflow();
        test_random_batches(140);
        test_back_to_back(40);
        test_random_batches(70);

        // drain, then give stray reports time to show up
        wait_reports_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d circles in %0d batches (%0d overflowed the store).",
                 circles_sent, batches_sent, ovf_batches);
        $display("Checked %0d reports, %0d of them collisions; %0d mismatches.",
                 reports_seen, hits_seen, errors);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### files.f
src/cpcf_pkg.sv
src/cpcf_if.sv
src/cpcf_ram.sv
src/cpcf_dp.sv
src/cpcf_ctrl.sv
src/circle_pair_collision_finder_unit.sv
dv/tb.sv
